// ----- rtl/mlr_pkg.sv -----
`timescale 1ns / 1ps

package mlr_pkg;

  // Fixed field widths of the channels and the size register
  localparam int ELEM_W = 32;
  localparam int RUN_W  = 7;
  localparam int SIZE_W = 7;

  // Defaults handed to the top level parameters
  localparam int DEF_MAX_SIZE    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  // Matrix size after reset
  localparam int RESET_SIZE = 8;

  typedef logic [RUN_W-1:0] run_t;

  localparam run_t RUN_ONE = run_t'(1);
  localparam run_t RUN_MAX = run_t'((1 << RUN_W) - 1);

  // Run lengths kept per column of the previous row
  typedef struct packed {
    run_t vert;
    run_t diag;
    run_t anti;
  } run_set_t;

  // Extend a run by one, saturating at the top of the field
  function automatic run_t run_bump(input run_t run);
    run_t res;
    if (run == RUN_MAX) begin
      res = run;
    end else begin
      res = run + RUN_ONE;
    end
    return res;
  endfunction

endpackage

// ----- rtl/mlr_if.sv -----
`timescale 1ns / 1ps

// Element stream: one matrix element per item
interface mlr_elem_if;
  logic                                valid;
  logic                                ready;
  logic signed [mlr_pkg::ELEM_W-1:0]   element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// Result stream: one longest run per matrix
interface mlr_run_if;
  logic                         valid;
  logic                         ready;
  logic [mlr_pkg::RUN_W-1:0]    longest_run;

  modport source (output valid, output longest_run, input ready);
  modport sink   (input valid, input longest_run, output ready);
endinterface

// ----- rtl/mlr_line_buf.sv -----
`timescale 1ns / 1ps

// Variable-length line buffer holding the previous row. Slot 0 is the entry
// of the current column, slot 1 the column to its right. Each step shifts by
// one and pushes the new entry in at the slot of the last column in use.
module mlr_line_buf #(
  parameter int MAX_SIZE = mlr_pkg::DEF_MAX_SIZE,
  parameter int DATA_W   = mlr_pkg::DEF_VALUE_WIDTH,
  localparam int POS_W   = $clog2(MAX_SIZE)
) (
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic [POS_W-1:0]      last_idx_i,
  input  logic [DATA_W-1:0]     wr_value_i,
  input  mlr_pkg::run_set_t     wr_runs_i,
  output logic [DATA_W-1:0]     head_value_o,
  output mlr_pkg::run_set_t     head_runs_o,
  output logic [DATA_W-1:0]     next_value_o,
  output mlr_pkg::run_set_t     next_runs_o
);

  logic [DATA_W-1:0]  value_q [MAX_SIZE];
  mlr_pkg::run_set_t  runs_q  [MAX_SIZE];

  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_slot
    logic [DATA_W-1:0] value_d;
    mlr_pkg::run_set_t runs_d;

    if (i < MAX_SIZE - 1) begin : g_mid
      logic tail;
      assign tail    = (last_idx_i == POS_W'(i));
      assign value_d = tail ? wr_value_i : value_q[i+1];
      assign runs_d  = tail ? wr_runs_i  : runs_q[i+1];
    end else begin : g_end
      assign value_d = wr_value_i;
      assign runs_d  = wr_runs_i;
    end

    always_ff @(posedge clk_i) begin
      if (shift_i) begin
        value_q[i] <= value_d;
        runs_q[i]  <= runs_d;
      end
    end
  end

  assign head_value_o = value_q[0];
  assign head_runs_o  = runs_q[0];
  assign next_value_o = value_q[1];
  assign next_runs_o  = runs_q[1];

endmodule

// ----- rtl/mlr_step.sv -----
`timescale 1ns / 1ps

// Run update for one element: position counters, horizontal run,
// above-left history and the best run of the matrix in progress.
module mlr_step #(
  parameter int MAX_SIZE = mlr_pkg::DEF_MAX_SIZE,
  parameter int DATA_W   = mlr_pkg::DEF_VALUE_WIDTH,
  localparam int POS_W   = $clog2(MAX_SIZE)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  restart_i,
  input  logic [POS_W-1:0]      last_idx_i,
  input  logic [DATA_W-1:0]     value_i,
  input  logic [DATA_W-1:0]     head_value_i,
  input  mlr_pkg::run_set_t     head_runs_i,
  input  logic [DATA_W-1:0]     next_value_i,
  input  mlr_pkg::run_set_t     next_runs_i,
  output mlr_pkg::run_set_t     wr_runs_o,
  output logic                  done_o,
  output mlr_pkg::run_t         best_o
);

  logic [POS_W-1:0]  col_q, col_d, row_q, row_d;
  mlr_pkg::run_t     horiz_q, horiz_d, best_q, best_d;
  logic [DATA_W-1:0] left_q, al_value_q;
  mlr_pkg::run_t     al_diag_q;

  logic              col_first, row_first, col_last, row_last;
  mlr_pkg::run_t     hr, vr, dr, ar, m;

  always_comb begin
    col_first = (col_q == '0);
    row_first = (row_q == '0);
    col_last  = (col_q == last_idx_i);
    row_last  = (row_q == last_idx_i);

    hr = (!col_first && left_q == value_i) ? mlr_pkg::run_bump(horiz_q) : mlr_pkg::RUN_ONE;
    vr = mlr_pkg::RUN_ONE;
    dr = mlr_pkg::RUN_ONE;
    ar = mlr_pkg::RUN_ONE;
    if (!row_first) begin
      if (head_value_i == value_i) begin
        vr = mlr_pkg::run_bump(head_runs_i.vert);
      end
      if (!col_first && al_value_q == value_i) begin
        dr = mlr_pkg::run_bump(al_diag_q);
      end
      if (!col_last && next_value_i == value_i) begin
        ar = mlr_pkg::run_bump(next_runs_i.anti);
      end
    end

    m = best_q;
    if (hr > m) m = hr;
    if (vr > m) m = vr;
    if (dr > m) m = dr;
    if (ar > m) m = ar;
  end

  // Advance the raster position; a restart or the last element starts a fresh matrix
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    horiz_d = horiz_q;
    best_d  = best_q;
    if (restart_i) begin
      col_d   = '0;
      row_d   = '0;
      horiz_d = mlr_pkg::RUN_ONE;
      best_d  = mlr_pkg::RUN_ONE;
    end else if (step_i) begin
      if (col_last) begin
        col_d   = '0;
        horiz_d = mlr_pkg::RUN_ONE;
        row_d   = row_last ? '0 : row_q + POS_W'(1);
      end else begin
        col_d   = col_q + POS_W'(1);
        horiz_d = hr;
      end
      best_d = (col_last && row_last) ? mlr_pkg::RUN_ONE : m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      horiz_q <= mlr_pkg::RUN_ONE;
      best_q  <= mlr_pkg::RUN_ONE;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      horiz_q <= horiz_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !restart_i) begin
      left_q     <= value_i;
      al_value_q <= head_value_i;
      al_diag_q  <= head_runs_i.diag;
    end
  end

  assign wr_runs_o = '{vert: vr, diag: dr, anti: ar};
  assign done_o    = col_last && row_last;
  assign best_o    = m;

endmodule

// ----- rtl/matrix_longest_equal_run_top.sv -----
`timescale 1ns / 1ps

// Longest run of equal values in a square matrix.
//
// elem_in takes the matrix elements in row-major order, one per item, for a
// matrix of cfg_wdata_i rows and columns (0 acts as 1, sizes above MAX_SIZE
// act as MAX_SIZE). After the last element run_out gives one item: the
// longest run of equal neighbours along a row, a column, a diagonal or an
// anti-diagonal. Only the low VALUE_WIDTH bits of an element are compared.
// Writing the size (cfg_we_i high at a clock edge) drops any matrix in
// progress; write it only while the block is idle.
//
// Throughput is one element per cycle unless a finished result waits on
// run_out. An accepted element lands in the input register and is folded
// into the run state from there; on the last element the result is loaded
// into the output register at the same edge, which raises run_out.valid.
// If run_out stalls, elements that do not finish a matrix keep flowing; the
// last element of the next matrix waits in the input register until the
// pending result is taken. Reset gives size min(8, MAX_SIZE), an empty matrix.
module matrix_longest_equal_run_top #(
  parameter int MAX_SIZE    = mlr_pkg::DEF_MAX_SIZE,
  parameter int VALUE_WIDTH = mlr_pkg::DEF_VALUE_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mlr_elem_if.sink                    elem_in,
  mlr_run_if.source                   run_out,
  input  logic                        cfg_we_i,
  input  logic [mlr_pkg::SIZE_W-1:0]  cfg_wdata_i
);

  localparam int POS_W    = $clog2(MAX_SIZE);
  // Compared element bits: the port carries no more than ELEM_W
  localparam int CMP_W    = (VALUE_WIDTH < mlr_pkg::ELEM_W) ? VALUE_WIDTH : mlr_pkg::ELEM_W;
  localparam int SZ_CMP_W = (POS_W + 1 > mlr_pkg::SIZE_W) ? POS_W + 1 : mlr_pkg::SIZE_W;
  localparam int RESET_LAST =
    ((mlr_pkg::RESET_SIZE > MAX_SIZE) ? MAX_SIZE : mlr_pkg::RESET_SIZE) - 1;

  // Size register, kept as the index of the last row and column
  logic [POS_W-1:0]    last_idx_q, last_idx_d;
  logic [SZ_CMP_W-1:0] size_ext;

  always_comb begin
    size_ext = SZ_CMP_W'(cfg_wdata_i);
    if (size_ext == '0) begin
      last_idx_d = '0;
    end else if (size_ext > SZ_CMP_W'(MAX_SIZE)) begin
      last_idx_d = POS_W'(MAX_SIZE - 1);
    end else begin
      last_idx_d = POS_W'(size_ext - SZ_CMP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= POS_W'(RESET_LAST);
    end else if (cfg_we_i) begin
      last_idx_q <= last_idx_d;
    end
  end

  // Input register
  logic             in_valid_q;
  logic [CMP_W-1:0] in_value_q;
  logic             step;
  logic             done;
  mlr_pkg::run_t    best;

  // Hold the element while it would finish a matrix and the result slot is full
  assign step          = in_valid_q && (!done || !run_out.valid || run_out.ready);
  assign elem_in.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (elem_in.ready) begin
      in_valid_q <= elem_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_in.ready && elem_in.valid) begin
      in_value_q <= elem_in.element_value[CMP_W-1:0];
    end
  end

  // Previous row and its run lengths
  logic [CMP_W-1:0]  head_value, next_value;
  mlr_pkg::run_set_t head_runs, next_runs, wr_runs;

  mlr_line_buf #(
    .MAX_SIZE (MAX_SIZE),
    .DATA_W   (CMP_W)
  ) u_line_buf (
    .clk_i        (clk_i),
    .shift_i      (step),
    .last_idx_i   (last_idx_q),
    .wr_value_i   (in_value_q),
    .wr_runs_i    (wr_runs),
    .head_value_o (head_value),
    .head_runs_o  (head_runs),
    .next_value_o (next_value),
    .next_runs_o  (next_runs)
  );

  mlr_step #(
    .MAX_SIZE (MAX_SIZE),
    .DATA_W   (CMP_W)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .restart_i    (cfg_we_i),
    .last_idx_i   (last_idx_q),
    .value_i      (in_value_q),
    .head_value_i (head_value),
    .head_runs_i  (head_runs),
    .next_value_i (next_value),
    .next_runs_i  (next_runs),
    .wr_runs_o    (wr_runs),
    .done_o       (done),
    .best_o       (best)
  );

  // Result register: load on the last element, drop once taken
  logic          out_valid_q;
  mlr_pkg::run_t out_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && done) begin
      out_valid_q <= 1'b1;
    end else if (run_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && done) begin
      out_run_q <= best;
    end
  end

  assign run_out.valid       = out_valid_q;
  assign run_out.longest_run = out_run_q;

endmodule
